@@ src/mcfd_pkg.sv @@
// Package for the motor command frame decoder.
// Holds shared types, command and opcode constants, and register indexes.
// No dependencies.
package mcfd_pkg;

   localparam int FRAME_BYTES_DEFAULT = 16;
   localparam int PAYLOAD_DEPTH = 5;

   localparam logic [7:0] SYNC_RESET = 8'hFF;
   localparam logic [7:0] STATION_RESET = 8'h01;
   localparam logic [15:0] SPEED_X_RESET = 16'd300;
   localparam logic [15:0] SPEED_Y_RESET = 16'd500;

   localparam logic [1:0] CSR_SYNC_BYTE = 2'd0;
   localparam logic [1:0] CSR_STATION_ID = 2'd1;
   localparam logic [1:0] CSR_SPEED_X = 2'd2;
   localparam logic [1:0] CSR_SPEED_Y = 2'd3;

   localparam logic [2:0] CMD_UNKNOWN = 3'd0;
   localparam logic [2:0] CMD_ACTIVATE = 3'd1;
   localparam logic [2:0] CMD_RUN_X = 3'd2;
   localparam logic [2:0] CMD_RUN_Y = 3'd3;
   localparam logic [2:0] CMD_BRAKE = 3'd4;
   localparam logic [2:0] CMD_SET_TARGETS = 3'd5;
   localparam logic [2:0] CMD_STATUS = 3'd6;

   localparam logic [7:0] OP_ACTIVATE = 8'd0;
   localparam logic [7:0] OP_SET_TARGETS = 8'd7;
   localparam logic [7:0] OP_STATUS = 8'd8;
   localparam logic [7:0] OP_RUN_X = 8'd9;
   localparam logic [7:0] OP_RUN_Y = 8'd10;
   localparam logic [7:0] OP_BRAKE = 8'd12;

   localparam logic [7:0] SEL_AXIS_X = 8'd9;
   localparam logic [7:0] SEL_AXIS_Y = 8'd10;
   localparam logic [7:0] RAW_CCW = 8'd0;
   localparam logic [7:0] RAW_CW = 8'd1;

   localparam logic [1:0] DIR_CCW = 2'd0;
   localparam logic [1:0] DIR_CW = 2'd1;
   localparam logic [1:0] DIR_KEEP = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_NONE = 2'd2;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_SYNC2 = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] sync_byte;
      logic [7:0] station_id;
      logic [15:0] speed_x;
      logic [15:0] speed_y;
   } csr_type;

   typedef struct packed {
      logic done;
      logic overlong;
      logic [PAYLOAD_DEPTH-1:0][7:0] bytes;
   } frame_type;

   typedef struct packed {
      logic [2:0] command;
      logic [15:0] speed_x;
      logic [1:0] dir_x;
      logic [15:0] speed_y;
      logic [1:0] dir_y;
      logic [1:0] brake_axis;
      logic [15:0] target_x;
      logic [15:0] target_y;
      logic too_long;
   } result_type;

endpackage

@@ src/mcfd_csr.sv @@
// Configuration registers of the motor command frame decoder.
// Depends on mcfd_pkg for the register indexes and the csr_type struct.
module mcfd_csr (
   input logic clock,
   input logic reset,
   input logic csr_valid,
   input logic [1:0] csr_index,
   input logic [15:0] csr_wdata,
   output mcfd_pkg::csr_type regs
);

   mcfd_pkg::csr_type regs_ff;
   mcfd_pkg::csr_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         case (csr_index)
            mcfd_pkg::CSR_SYNC_BYTE: regs_in.sync_byte = csr_wdata[7:0];
            mcfd_pkg::CSR_STATION_ID: regs_in.station_id = csr_wdata[7:0];
            mcfd_pkg::CSR_SPEED_X: regs_in.speed_x = csr_wdata;
            mcfd_pkg::CSR_SPEED_Y: regs_in.speed_y = csr_wdata;
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.sync_byte <= mcfd_pkg::SYNC_RESET;
         regs_ff.station_id <= mcfd_pkg::STATION_RESET;
         regs_ff.speed_x <= mcfd_pkg::SPEED_X_RESET;
         regs_ff.speed_y <= mcfd_pkg::SPEED_Y_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

@@ src/mcfd_assembler.sv @@
// Frame assembler: tracks sync, station id and length, and stores the first
// payload bytes. Depends on mcfd_pkg for phase, csr and frame types.
module mcfd_assembler #(
   parameter int FrameBytes = mcfd_pkg::FRAME_BYTES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic accept,
   input logic [7:0] rx_byte,
   input mcfd_pkg::csr_type regs,
   output mcfd_pkg::frame_type frame
);

   localparam logic [9:0] FRAME_LIMIT = 10'(FrameBytes);

   mcfd_pkg::phase_type phase_ff, phase_in;
   logic [8:0] index_ff, index_in;
   logic [7:0] length_ff, length_in;
   logic [mcfd_pkg::PAYLOAD_DEPTH-1:0][7:0] payload_ff, payload_in;
   logic done_ff, done_in;
   logic overlong_ff, overlong_in;
   logic [2:0] slot;

   assign slot = index_ff[2:0] - 3'd4;

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      length_in = length_ff;
      payload_in = payload_ff;
      done_in = 1'b0;
      overlong_in = overlong_ff;
      if (accept) begin
         case (phase_ff)
            mcfd_pkg::PH_SYNC2: begin
               if (rx_byte == regs.sync_byte) begin
                  phase_in = mcfd_pkg::PH_BODY;
                  index_in = 9'd2;
               end else begin
                  phase_in = mcfd_pkg::PH_WAIT;
                  index_in = '0;
                  length_in = '0;
               end
            end
            mcfd_pkg::PH_BODY: begin
               if (index_ff == 9'd2) begin
                  if (rx_byte == regs.station_id) begin
                     index_in = 9'd3;
                  end else begin
                     phase_in = mcfd_pkg::PH_WAIT;
                     index_in = '0;
                     length_in = '0;
                  end
               end else if (index_ff == 9'd3) begin
                  length_in = rx_byte;
                  if (rx_byte == 8'd0) begin
                     phase_in = mcfd_pkg::PH_WAIT;
                     index_in = '0;
                  end else begin
                     index_in = 9'd4;
                  end
               end else begin
                  if (index_ff >= 9'd4 && index_ff <= 9'd8) begin
                     payload_in[slot] = rx_byte;
                  end
                  if (index_ff >= ({1'b0, length_ff} + 9'd3)) begin
                     done_in = 1'b1;
                     overlong_in = ({2'b00, length_ff} + 10'd3) >= FRAME_LIMIT;
                     phase_in = mcfd_pkg::PH_WAIT;
                     index_in = '0;
                     length_in = '0;
                  end else begin
                     index_in = index_ff + 9'd1;
                  end
               end
            end
            default: begin
               if (rx_byte == regs.sync_byte) begin
                  payload_in = '0;
                  phase_in = mcfd_pkg::PH_SYNC2;
                  index_in = 9'd1;
               end else begin
                  phase_in = mcfd_pkg::PH_WAIT;
                  index_in = '0;
               end
               length_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mcfd_pkg::PH_WAIT;
         index_ff <= '0;
         length_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         length_ff <= length_in;
         done_ff <= done_in;
      end
      payload_ff <= payload_in;
      overlong_ff <= overlong_in;
   end

   assign frame.done = done_ff;
   assign frame.overlong = overlong_ff;
   assign frame.bytes = payload_ff;

endmodule

@@ src/mcfd_decoder.sv @@
// Command decoder: turns the stored payload bytes of a finished frame into
// one result. Depends on mcfd_pkg for frame, csr and result types.
module mcfd_decoder (
   input mcfd_pkg::frame_type frame,
   input mcfd_pkg::csr_type regs,
   output mcfd_pkg::result_type result
);

   function automatic logic [1:0] dir_code(input logic [7:0] raw);
      logic [1:0] code;
      if (raw == mcfd_pkg::RAW_CCW) begin
         code = mcfd_pkg::DIR_CCW;
      end else if (raw == mcfd_pkg::RAW_CW) begin
         code = mcfd_pkg::DIR_CW;
      end else begin
         code = mcfd_pkg::DIR_KEEP;
      end
      return code;
   endfunction

   always_comb begin
      result = '0;
      result.command = mcfd_pkg::CMD_UNKNOWN;
      result.dir_x = mcfd_pkg::DIR_KEEP;
      result.dir_y = mcfd_pkg::DIR_KEEP;
      result.brake_axis = mcfd_pkg::AXIS_NONE;
      result.too_long = frame.overlong;
      if (!frame.overlong) begin
         case (frame.bytes[0])
            mcfd_pkg::OP_ACTIVATE: begin
               result.command = mcfd_pkg::CMD_ACTIVATE;
               result.speed_x = regs.speed_x;
               result.dir_x = mcfd_pkg::DIR_CW;
               result.speed_y = regs.speed_y;
               result.dir_y = mcfd_pkg::DIR_CW;
            end
            mcfd_pkg::OP_RUN_X: begin
               result.command = mcfd_pkg::CMD_RUN_X;
               result.speed_x = {frame.bytes[1], frame.bytes[2]};
               result.dir_x = dir_code(frame.bytes[3]);
            end
            mcfd_pkg::OP_RUN_Y: begin
               result.command = mcfd_pkg::CMD_RUN_Y;
               result.speed_y = {frame.bytes[1], frame.bytes[2]};
               result.dir_y = dir_code(frame.bytes[3]);
            end
            mcfd_pkg::OP_BRAKE: begin
               result.command = mcfd_pkg::CMD_BRAKE;
               if (frame.bytes[1] == mcfd_pkg::SEL_AXIS_X) begin
                  result.brake_axis = mcfd_pkg::AXIS_X;
               end else if (frame.bytes[1] == mcfd_pkg::SEL_AXIS_Y) begin
                  result.brake_axis = mcfd_pkg::AXIS_Y;
               end
            end
            mcfd_pkg::OP_SET_TARGETS: begin
               result.command = mcfd_pkg::CMD_SET_TARGETS;
               result.target_x = {frame.bytes[1], frame.bytes[2]};
               result.target_y = {frame.bytes[3], frame.bytes[4]};
            end
            mcfd_pkg::OP_STATUS: begin
               result.command = mcfd_pkg::CMD_STATUS;
            end
            default: begin
               result.command = mcfd_pkg::CMD_UNKNOWN;
            end
         endcase
      end
   end

endmodule

@@ src/mcfd_out_buffer.sv @@
// Result register with a skid entry behind it, so a decoded result is never
// dropped while the output is stalled. Depends on mcfd_pkg for result_type.
module mcfd_out_buffer (
   input logic clock,
   input logic reset,
   input logic load,
   input mcfd_pkg::result_type result,
   input logic rsp_stall,
   output logic rsp_valid,
   output mcfd_pkg::result_type rsp_result,
   output logic full
);

   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   mcfd_pkg::result_type out_ff, out_in;
   mcfd_pkg::result_type skid_ff, skid_in;
   logic out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in = out_ff;
      skid_in = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = load;
            skid_in = result;
         end else begin
            out_in = result;
            out_valid_in = load;
         end
      end else if (load) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_result = out_ff;
   assign full = skid_valid_ff;

endmodule

@@ src/motor_command_frame_decoder.sv @@
// Motor command frame decoder, top level.
// Instantiates mcfd_csr, mcfd_assembler, mcfd_decoder and mcfd_out_buffer.
//
// The decoder takes one received byte per clock cycle while req_stall is low
// and emits one result per completed frame (sync, sync, station id, length,
// payload). When the final byte is accepted the assembler registers its done
// flag (and that byte, if it falls in a stored payload slot); the decoder is
// combinational, so the result is then loaded into the output register, which
// raises rsp_valid, or into the skid entry while the output is stalled. The skid
// entry behind the output register lets bytes keep flowing while one result
// waits; req_stall is raised only while a second finished result is also waiting.
// Configuration writes are always taken (csr_ready is tied high) and must be issued while no frame is in progress.
module motor_command_frame_decoder #(
   parameter int FrameBytes = mcfd_pkg::FRAME_BYTES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [2:0] rsp_command,
   output logic [15:0] rsp_speed_x,
   output logic [1:0] rsp_dir_x,
   output logic [15:0] rsp_speed_y,
   output logic [1:0] rsp_dir_y,
   output logic [1:0] rsp_brake_axis,
   output logic [15:0] rsp_target_x,
   output logic [15:0] rsp_target_y,
   output logic rsp_too_long,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [15:0] csr_wdata
);

   mcfd_pkg::csr_type regs;
   mcfd_pkg::frame_type frame;
   mcfd_pkg::result_type decoded;
   mcfd_pkg::result_type rsp_result;
   logic buffer_full;
   logic accept;

   assign csr_ready = 1'b1;
   assign req_stall = buffer_full;
   assign accept = req_valid && !req_stall;

   mcfd_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .regs(regs)
   );

   mcfd_assembler #(
      .FrameBytes(FrameBytes)
   ) u_assembler (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .rx_byte(req_rx_byte),
      .regs(regs),
      .frame(frame)
   );

   mcfd_decoder u_decoder (
      .frame(frame),
      .regs(regs),
      .result(decoded)
   );

   mcfd_out_buffer u_out_buffer (
      .clock(clock),
      .reset(reset),
      .load(frame.done),
      .result(decoded),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_result(rsp_result),
      .full(buffer_full)
   );

   assign rsp_command = rsp_result.command;
   assign rsp_speed_x = rsp_result.speed_x;
   assign rsp_dir_x = rsp_result.dir_x;
   assign rsp_speed_y = rsp_result.speed_y;
   assign rsp_dir_y = rsp_result.dir_y;
   assign rsp_brake_axis = rsp_result.brake_axis;
   assign rsp_target_x = rsp_result.target_x;
   assign rsp_target_y = rsp_result.target_y;
   assign rsp_too_long = rsp_result.too_long;

endmodule

@@ src/mcfd_checker.sv @@
// Port-level checks for the motor command frame decoder, bound to the top.
// Depends on mcfd_pkg for command and direction codes.
module mcfd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [2:0] rsp_command,
   input logic [1:0] rsp_dir_x,
   input logic [1:0] rsp_dir_y,
   input logic [15:0] rsp_target_x,
   input logic rsp_too_long
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_command)
         && $stable(rsp_target_x))
      else $error("Stalled result changed.");

   a_long_unknown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_command == mcfd_pkg::CMD_UNKNOWN)
      else $error("Overlong frame carries a command.");

   a_activate_dirs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command == mcfd_pkg::CMD_ACTIVATE
         |-> rsp_dir_x == mcfd_pkg::DIR_CW && rsp_dir_y == mcfd_pkg::DIR_CW)
      else $error("Activate result without clockwise directions.");

endmodule

bind motor_command_frame_decoder mcfd_checker u_mcfd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_command(rsp_command),
   .rsp_dir_x(rsp_dir_x),
   .rsp_dir_y(rsp_dir_y),
   .rsp_target_x(rsp_target_x),
   .rsp_too_long(rsp_too_long)
);

@@ tb/motor_command_frame_decoder_test.sv @@
// Self-checking testbench for motor_command_frame_decoder.
// A queue-fed byte driver, a randomly stalling result sink and a frame predictor
// are used. Depends on mcfd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module motor_command_frame_decoder_test;

   localparam int FRAME_LIMIT = mcfd_pkg::FRAME_BYTES_DEFAULT;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_rx_byte;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_command;
   logic [15:0] rsp_speed_x;
   logic [1:0] rsp_dir_x;
   logic [15:0] rsp_speed_y;
   logic [1:0] rsp_dir_y;
   logic [1:0] rsp_brake_axis;
   logic [15:0] rsp_target_x;
   logic [15:0] rsp_target_y;
   logic rsp_too_long;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_wdata;

   motor_command_frame_decoder #(
      .FrameBytes(FRAME_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command(rsp_command),
      .rsp_speed_x(rsp_speed_x),
      .rsp_dir_x(rsp_dir_x),
      .rsp_speed_y(rsp_speed_y),
      .rsp_dir_y(rsp_dir_y),
      .rsp_brake_axis(rsp_brake_axis),
      .rsp_target_x(rsp_target_x),
      .rsp_target_y(rsp_target_y),
      .rsp_too_long(rsp_too_long),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   logic [7:0] rx_bytes_pending[$];
   mcfd_pkg::result_type expected_results[$];
   int bytes_queued = 0;
   int bytes_taken = 0;
   int mismatch_count = 0;

   logic byte_accepted;
   logic result_accepted;
   int req_gap = 0;
   int rsp_hold = 0;
   bit req_burst = 0;
   bit rsp_burst = 0;

   mcfd_pkg::csr_type model_csr;
   mcfd_pkg::phase_type rx_phase;
   logic [8:0] byte_index;
   logic [7:0] frame_length;
   logic [7:0] frame_payload[mcfd_pkg::PAYLOAD_DEPTH];
   mcfd_pkg::result_type seen_result;
   mcfd_pkg::result_type want_result;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** motor_command_frame_decoder: FAILED **");
      $finish;
   end

   function automatic int draw_wait(inout bit burst);
      if ($urandom_range(0, 31) == 0) begin
         burst = !burst;
      end
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic logic [1:0] dir_from_raw(logic [7:0] raw);
      if (raw == mcfd_pkg::RAW_CCW) begin
         return mcfd_pkg::DIR_CCW;
      end
      if (raw == mcfd_pkg::RAW_CW) begin
         return mcfd_pkg::DIR_CW;
      end
      return mcfd_pkg::DIR_KEEP;
   endfunction

   function automatic mcfd_pkg::result_type decode_frame(bit overlong);
      mcfd_pkg::result_type r;
      r = '0;
      r.command = mcfd_pkg::CMD_UNKNOWN;
      r.dir_x = mcfd_pkg::DIR_KEEP;
      r.dir_y = mcfd_pkg::DIR_KEEP;
      r.brake_axis = mcfd_pkg::AXIS_NONE;
      if (overlong) begin
         r.too_long = 1'b1;
      end else begin
         case (frame_payload[0])
            mcfd_pkg::OP_ACTIVATE: begin
               r.command = mcfd_pkg::CMD_ACTIVATE;
               r.speed_x = model_csr.speed_x;
               r.dir_x = mcfd_pkg::DIR_CW;
               r.speed_y = model_csr.speed_y;
               r.dir_y = mcfd_pkg::DIR_CW;
            end
            mcfd_pkg::OP_RUN_X: begin
               r.command = mcfd_pkg::CMD_RUN_X;
               r.speed_x = {frame_payload[1], frame_payload[2]};
               r.dir_x = dir_from_raw(frame_payload[3]);
            end
            mcfd_pkg::OP_RUN_Y: begin
               r.command = mcfd_pkg::CMD_RUN_Y;
               r.speed_y = {frame_payload[1], frame_payload[2]};
               r.dir_y = dir_from_raw(frame_payload[3]);
            end
            mcfd_pkg::OP_BRAKE: begin
               r.command = mcfd_pkg::CMD_BRAKE;
               if (frame_payload[1] == mcfd_pkg::SEL_AXIS_X) begin
                  r.brake_axis = mcfd_pkg::AXIS_X;
               end else if (frame_payload[1] == mcfd_pkg::SEL_AXIS_Y) begin
                  r.brake_axis = mcfd_pkg::AXIS_Y;
               end
            end
            mcfd_pkg::OP_SET_TARGETS: begin
               r.command = mcfd_pkg::CMD_SET_TARGETS;
               r.target_x = {frame_payload[1], frame_payload[2]};
               r.target_y = {frame_payload[3], frame_payload[4]};
            end
            mcfd_pkg::OP_STATUS: begin
               r.command = mcfd_pkg::CMD_STATUS;
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   task automatic drop_to_wait();
      rx_phase = mcfd_pkg::PH_WAIT;
      byte_index = '0;
      frame_length = '0;
   endtask

   task automatic absorb_rx_byte(input logic [7:0] b);
      int slot;
      case (rx_phase)
         mcfd_pkg::PH_SYNC2: begin
            if (b == model_csr.sync_byte) begin
               rx_phase = mcfd_pkg::PH_BODY;
               byte_index = 9'd2;
            end else begin
               drop_to_wait();
            end
         end
         mcfd_pkg::PH_BODY: begin
            if (byte_index == 9'd2) begin
               if (b == model_csr.station_id) begin
                  byte_index = 9'd3;
               end else begin
                  drop_to_wait();
               end
            end else if (byte_index == 9'd3) begin
               frame_length = b;
               if (b == 8'd0) begin
                  drop_to_wait();
               end else begin
                  byte_index = 9'd4;
               end
            end else begin
               slot = int'(byte_index) - 4;
               if (slot >= 0 && slot < mcfd_pkg::PAYLOAD_DEPTH) begin
                  frame_payload[slot] = b;
               end
               if (int'(byte_index) >= 3 + int'(frame_length)) begin
                  expected_results.push_back(
                     decode_frame(3 + int'(frame_length) >= FRAME_LIMIT));
                  drop_to_wait();
               end else begin
                  byte_index = byte_index + 9'd1;
               end
            end
         end
         default: begin
            if (b == model_csr.sync_byte) begin
               foreach (frame_payload[i]) frame_payload[i] = '0;
               rx_phase = mcfd_pkg::PH_SYNC2;
               byte_index = 9'd1;
               frame_length = '0;
            end else begin
               drop_to_wait();
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_accepted <= 1'b0;
         result_accepted <= 1'b0;
         model_csr = '{mcfd_pkg::SYNC_RESET, mcfd_pkg::STATION_RESET,
                       mcfd_pkg::SPEED_X_RESET, mcfd_pkg::SPEED_Y_RESET};
         drop_to_wait();
         foreach (frame_payload[i]) frame_payload[i] = '0;
      end else begin
         byte_accepted <= req_valid && !req_stall;
         result_accepted <= rsp_valid && !rsp_stall;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mcfd_pkg::CSR_SYNC_BYTE: model_csr.sync_byte = csr_wdata[7:0];
               mcfd_pkg::CSR_STATION_ID: model_csr.station_id = csr_wdata[7:0];
               mcfd_pkg::CSR_SPEED_X: model_csr.speed_x = csr_wdata;
               mcfd_pkg::CSR_SPEED_Y: model_csr.speed_y = csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            absorb_rx_byte(req_rx_byte);
            bytes_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            seen_result = {rsp_command, rsp_speed_x, rsp_dir_x, rsp_speed_y, rsp_dir_y,
                           rsp_brake_axis, rsp_target_x, rsp_target_y, rsp_too_long};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result command", 16'(seen_result.command),
                               16'd0);
            end else begin
               want_result = expected_results.pop_front();
               if (seen_result.command !== want_result.command)
                  report_mismatch("command", 16'(seen_result.command),
                                  16'(want_result.command));
               if (seen_result.speed_x !== want_result.speed_x)
                  report_mismatch("speed_x", seen_result.speed_x, want_result.speed_x);
               if (seen_result.dir_x !== want_result.dir_x)
                  report_mismatch("dir_x", 16'(seen_result.dir_x), 16'(want_result.dir_x));
               if (seen_result.speed_y !== want_result.speed_y)
                  report_mismatch("speed_y", seen_result.speed_y, want_result.speed_y);
               if (seen_result.dir_y !== want_result.dir_y)
                  report_mismatch("dir_y", 16'(seen_result.dir_y), 16'(want_result.dir_y));
               if (seen_result.brake_axis !== want_result.brake_axis)
                  report_mismatch("brake_axis", 16'(seen_result.brake_axis),
                                  16'(want_result.brake_axis));
               if (seen_result.target_x !== want_result.target_x)
                  report_mismatch("target_x", seen_result.target_x, want_result.target_x);
               if (seen_result.target_y !== want_result.target_y)
                  report_mismatch("target_y", seen_result.target_y, want_result.target_y);
               if (seen_result.too_long !== want_result.too_long)
                  report_mismatch("too_long", 16'(seen_result.too_long),
                                  16'(want_result.too_long));
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || byte_accepted) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (rx_bytes_pending.size() > 0) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_bytes_pending.pop_front();
               req_gap = draw_wait(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (result_accepted) begin
            rsp_hold = draw_wait(rsp_burst);
         end
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      rx_bytes_pending.push_back(b);
      bytes_queued++;
   endtask

   function automatic logic [7:0] random_byte_except(logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom);
      while (b == avoid) b = 8'($urandom);
      return b;
   endfunction

   task automatic push_random_frame();
      int pick;
      int len;
      logic [7:0] op;
      logic [7:0] body;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         case ($urandom_range(0, 6))
            0: op = mcfd_pkg::OP_ACTIVATE;
            1: op = mcfd_pkg::OP_RUN_X;
            2: op = mcfd_pkg::OP_RUN_Y;
            3: op = mcfd_pkg::OP_BRAKE;
            4: op = mcfd_pkg::OP_SET_TARGETS;
            5: op = mcfd_pkg::OP_STATUS;
            default: op = 8'($urandom);
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 1) begin
            len = $urandom_range(200, 255);
         end else if (pick < 12) begin
            len = $urandom_range(13, 40);
         end else begin
            len = $urandom_range(1, 12);
         end
         push_byte(model_csr.sync_byte);
         push_byte(model_csr.sync_byte);
         push_byte(model_csr.station_id);
         push_byte(8'(len));
         for (int i = 0; i < len; i++) begin
            body = 8'($urandom);
            if (i == 0) begin
               body = op;
            end else if (i == 1 && op == mcfd_pkg::OP_BRAKE) begin
               case ($urandom_range(0, 2))
                  0: body = mcfd_pkg::SEL_AXIS_X;
                  1: body = mcfd_pkg::SEL_AXIS_Y;
                  default: body = 8'($urandom);
               endcase
            end else if (i == 3 && (op == mcfd_pkg::OP_RUN_X || op == mcfd_pkg::OP_RUN_Y))
            begin
               case ($urandom_range(0, 2))
                  0: body = mcfd_pkg::RAW_CCW;
                  1: body = mcfd_pkg::RAW_CW;
                  default: body = 8'($urandom);
               endcase
            end
            push_byte(body);
         end
      end else if (pick < 78) begin
         push_byte(model_csr.sync_byte);
         push_byte(random_byte_except(model_csr.sync_byte));
      end else if (pick < 84) begin
         push_byte(model_csr.sync_byte);
         push_byte(model_csr.sync_byte);
         push_byte(random_byte_except(model_csr.station_id));
      end else if (pick < 90) begin
         push_byte(model_csr.sync_byte);
         push_byte(model_csr.sync_byte);
         push_byte(model_csr.station_id);
         push_byte(8'd0);
      end else begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end
   endtask

   task automatic send_random_traffic(input int byte_budget);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < byte_budget) push_random_frame();
   endtask

   task automatic wait_drained();
      while (bytes_taken != bytes_queued || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic reconfigure(input logic [7:0] sync_value, input logic [7:0] station,
                              input logic [15:0] speed_x, input logic [15:0] speed_y);
      wait_drained();
      while (rx_phase != mcfd_pkg::PH_WAIT) begin
         if (rx_phase == mcfd_pkg::PH_SYNC2) begin
            push_byte(random_byte_except(model_csr.sync_byte));
         end else if (byte_index == 9'd2) begin
            push_byte(random_byte_except(model_csr.station_id));
         end else if (byte_index == 9'd3) begin
            push_byte(8'd0);
         end else begin
            push_byte(8'($urandom));
         end
         wait_drained();
      end
      repeat (5) @(negedge clock);
      csr_write(mcfd_pkg::CSR_SYNC_BYTE, {8'd0, sync_value});
      csr_write(mcfd_pkg::CSR_STATION_ID, {8'd0, station});
      csr_write(mcfd_pkg::CSR_SPEED_X, speed_x);
      csr_write(mcfd_pkg::CSR_SPEED_Y, speed_y);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = mcfd_pkg::CSR_SYNC_BYTE;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Activate, brake Y, zero length, wrong station, wrong second sync, status.
      push_byte(mcfd_pkg::SYNC_RESET); push_byte(mcfd_pkg::SYNC_RESET);
      push_byte(mcfd_pkg::STATION_RESET);
      push_byte(8'd1); push_byte(mcfd_pkg::OP_ACTIVATE);
      push_byte(mcfd_pkg::SYNC_RESET); push_byte(mcfd_pkg::SYNC_RESET);
      push_byte(mcfd_pkg::STATION_RESET);
      push_byte(8'd2); push_byte(mcfd_pkg::OP_BRAKE); push_byte(mcfd_pkg::SEL_AXIS_Y);
      push_byte(mcfd_pkg::SYNC_RESET); push_byte(mcfd_pkg::SYNC_RESET);
      push_byte(mcfd_pkg::STATION_RESET);
      push_byte(8'd0);
      push_byte(mcfd_pkg::SYNC_RESET); push_byte(mcfd_pkg::SYNC_RESET); push_byte(8'd2);
      push_byte(mcfd_pkg::SYNC_RESET); push_byte(8'd0);
      push_byte(mcfd_pkg::SYNC_RESET); push_byte(mcfd_pkg::SYNC_RESET);
      push_byte(mcfd_pkg::STATION_RESET);
      push_byte(8'd1); push_byte(mcfd_pkg::OP_STATUS);
      wait_drained();

      send_random_traffic(150);
      reconfigure(8'h00, 8'h00, 16'd0, 16'd0);
      send_random_traffic(150);
      reconfigure(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_random_traffic(150);
      reconfigure(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      send_random_traffic(150);
      reconfigure(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      send_random_traffic(150);

      wait_drained();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("** motor_command_frame_decoder: PASSED **");
      end else begin
         $display("** motor_command_frame_decoder: FAILED **");
      end
      $finish;
   end

endmodule
